// ===== design/assert_macros.svh =====
// Assertion helpers for the design folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst, cond, prop, msg)

`define ASSERT_NEXT(label, clk, rst, cond, prop, msg)

`endif

`endif

// ===== design/dare_pkg.sv =====
package dare_pkg;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SHORT   = 3'd1;
  localparam logic [2:0] ST_IDBAD   = 3'd2;
  localparam logic [2:0] ST_FLAGBAD = 3'd3;
  localparam logic [2:0] ST_NOA     = 3'd4;

  localparam logic [7:0]  PTR_MARK    = 8'd192;
  localparam logic [15:0] A_LEN       = 16'd4;
  localparam logic [15:0] RR_TYPE_A   = 16'd1;
  localparam logic [15:0] RR_CLASS_IN = 16'd1;

  localparam logic [3:0] HDR_LAST  = 4'd11;
  localparam logic [3:0] QFIX_LAST = 4'd3;
  localparam logic [3:0] AFIX_LAST = 4'd9;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } dare_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] address;
  } dare_result_t;

endpackage

// ===== design/dare_in_reg.sv =====
module dare_in_reg
  import dare_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       last_byte,
  input  logic       take,
  output logic       held,
  output dare_item_t item
);

  logic accept;
  logic held_next;

  assign in_stall = held && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    held_next = held;
    if (accept) begin
      held_next = 1'b1;
    end else if (take) begin
      held_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.rx_byte   <= rx_byte;
      item.last_byte <= last_byte;
    end
  end

endmodule

// ===== design/dare_parser.sv =====
module dare_parser
  import dare_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  dare_item_t   item,
  input  logic [15:0]  expected_id,
  output dare_result_t result
);

  typedef enum logic [3:0] {
    PH_HDR,
    PH_NAME_LEN,
    PH_NAME_LABEL,
    PH_NAME_PTR,
    PH_QFIX,
    PH_AFIX,
    PH_RDATA,
    PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  offset, offset_next;
  logic [2:0]  outcome, outcome_next;
  logic [15:0] ident, ident_next;
  logic [15:0] flags, flags_next;
  logic [15:0] qleft, qleft_next;
  logic [15:0] aleft, aleft_next;
  logic [15:0] skip, skip_next;
  logic [15:0] rtype, rtype_next;
  logic [15:0] rclass, rclass_next;
  logic [15:0] rdlen, rdlen_next;
  logic [31:0] addr, addr_next;

  logic [7:0]  b;
  logic [15:0] rdlen_new;
  logic [15:0] q_dec;
  logic [15:0] a_dec;
  logic [15:0] skip_dec;
  logic        rec_hit;
  logic [2:0]  status_v;

  assign b         = item.rx_byte;
  assign rdlen_new = {rdlen[15:8], b};
  assign q_dec     = qleft - 16'd1;
  assign a_dec     = aleft - 16'd1;
  assign skip_dec  = skip - 16'd1;
  assign rec_hit   = (rtype == RR_TYPE_A) && (rclass == RR_CLASS_IN) && (rdlen == A_LEN);

  always_comb begin
    phase_next   = phase;
    offset_next  = offset;
    outcome_next = outcome;
    ident_next   = ident;
    flags_next   = flags;
    qleft_next   = qleft;
    aleft_next   = aleft;
    skip_next    = skip;
    rtype_next   = rtype;
    rclass_next  = rclass;
    rdlen_next   = rdlen;
    addr_next    = addr;
    case (phase)
      PH_HDR: begin
        case (offset)
          4'd0: ident_next = {b, 8'h00};
          4'd1: ident_next = {ident[15:8], b};
          4'd2: flags_next = {b, 8'h00};
          4'd3: flags_next = {flags[15:8], b};
          4'd4: qleft_next = {b, 8'h00};
          4'd5: qleft_next = {qleft[15:8], b};
          4'd6: aleft_next = {b, 8'h00};
          4'd7: aleft_next = {aleft[15:8], b};
          default: ;
        endcase
        if (offset < HDR_LAST) begin
          offset_next  = offset + 4'd1;
          outcome_next = ST_SHORT;
        end else begin
          offset_next = 4'd0;
          if (ident != expected_id) begin
            outcome_next = ST_IDBAD;
            phase_next   = PH_DONE;
          end else if (!flags[15] || (flags[3:0] != 4'd0)) begin
            outcome_next = ST_FLAGBAD;
            phase_next   = PH_DONE;
          end else begin
            outcome_next = ST_NOA;
            if (qleft != 16'd0) begin
              phase_next = PH_NAME_LEN;
            end else if (aleft != 16'd0) begin
              phase_next = PH_NAME_LEN;
            end else begin
              phase_next = PH_DONE;
            end
          end
        end
      end
      PH_NAME_LEN: begin
        if (b == 8'd0) begin
          offset_next = 4'd0;
          phase_next  = (qleft != 16'd0) ? PH_QFIX : PH_AFIX;
        end else if (b >= PTR_MARK) begin
          phase_next = PH_NAME_PTR;
        end else begin
          skip_next  = {8'h00, b};
          phase_next = PH_NAME_LABEL;
        end
      end
      PH_NAME_LABEL: begin
        skip_next = skip_dec;
        if (skip_dec == 16'd0) begin
          phase_next = PH_NAME_LEN;
        end
      end
      PH_NAME_PTR: begin
        offset_next = 4'd0;
        phase_next  = (qleft != 16'd0) ? PH_QFIX : PH_AFIX;
      end
      PH_QFIX: begin
        if (offset < QFIX_LAST) begin
          offset_next = offset + 4'd1;
        end else begin
          offset_next = 4'd0;
          qleft_next  = q_dec;
          if (q_dec != 16'd0) begin
            phase_next = PH_NAME_LEN;
          end else if (aleft != 16'd0) begin
            phase_next = PH_NAME_LEN;
          end else begin
            phase_next   = PH_DONE;
            outcome_next = ST_NOA;
          end
        end
      end
      PH_AFIX: begin
        case (offset)
          4'd0: rtype_next  = {b, 8'h00};
          4'd1: rtype_next  = {rtype[15:8], b};
          4'd2: rclass_next = {b, 8'h00};
          4'd3: rclass_next = {rclass[15:8], b};
          4'd8: rdlen_next  = {b, 8'h00};
          4'd9: rdlen_next  = rdlen_new;
          default: ;
        endcase
        if (offset < AFIX_LAST) begin
          offset_next = offset + 4'd1;
        end else begin
          offset_next = 4'd0;
          addr_next   = 32'd0;
          if (rdlen_new == 16'd0) begin
            aleft_next = a_dec;
            if (a_dec != 16'd0) begin
              phase_next = PH_NAME_LEN;
            end else begin
              phase_next   = PH_DONE;
              outcome_next = ST_NOA;
            end
          end else begin
            skip_next  = rdlen_new;
            phase_next = PH_RDATA;
          end
        end
      end
      PH_RDATA: begin
        if (rec_hit) begin
          addr_next = {addr[23:0], b};
        end
        skip_next = skip_dec;
        if (skip_dec == 16'd0) begin
          if (rec_hit) begin
            outcome_next = ST_OK;
            phase_next   = PH_DONE;
          end else begin
            aleft_next = a_dec;
            if (a_dec != 16'd0) begin
              phase_next = PH_NAME_LEN;
            end else begin
              phase_next   = PH_DONE;
              outcome_next = ST_NOA;
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign status_v       = (phase_next == PH_HDR) ? ST_SHORT : outcome_next;
  assign result.status  = status_v;
  assign result.address = (status_v == ST_OK) ? addr_next : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HDR;
      offset  <= 4'd0;
      outcome <= ST_NOA;
    end else if (step) begin
      if (item.last_byte) begin
        phase   <= PH_HDR;
        offset  <= 4'd0;
        outcome <= ST_NOA;
      end else begin
        phase   <= phase_next;
        offset  <= offset_next;
        outcome <= outcome_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      ident  <= ident_next;
      flags  <= flags_next;
      qleft  <= qleft_next;
      aleft  <= aleft_next;
      skip   <= skip_next;
      rtype  <= rtype_next;
      rclass <= rclass_next;
      rdlen  <= rdlen_next;
      addr   <= addr_next;
    end
  end

endmodule

// ===== design/dare_out_reg.sv =====
module dare_out_reg
  import dare_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  dare_result_t result,
  output logic         can_take,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [2:0]   status,
  output logic [31:0]  address
);

  logic out_valid_next;

  assign can_take = !out_valid || !out_stall;

  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (load) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status  <= result.status;
      address <= result.address;
    end
  end

endmodule

// ===== design/dns_a_record_extractor_core.sv =====
// DNS A-record extractor.
// Input channel: one payload byte per request on rx_byte, last_byte marks the
// final byte; in_valid/in_stall handshake, accepted when in_valid && !in_stall.
// Output channel: one request per payload, status and address, offered on
// out_valid and taken when out_valid && !out_stall.
// Configuration: expected_id written through cfg_valid/cfg_ready; cfg_ready is
// always high. Write it only while no payload is in flight.
// Throughput: one byte per cycle unless in_stall is raised, set by the parser
// update between the input register and the result register.
// The result for a payload is loaded into the result register from the input
// register holding its last byte, once the result register is free.
// When the receiver stalls, the result holds; a following last byte then
// waits in the input register and in_stall rises until the result is taken.
// Non-last bytes keep flowing during an output stall.
// Reset (rst, synchronous): parser returns to the header phase, both channels
// empty, expected_id cleared to zero.
`include "assert_macros.svh"

module dns_a_record_extractor_core
  import dare_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] address,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] expected_id
);

  logic         held;
  dare_item_t   item;
  logic         consume;
  logic         load;
  logic         can_take;
  dare_result_t result;
  logic [15:0]  exp_id;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_id <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      exp_id <= expected_id;
    end
  end

  assign consume = held && (!item.last_byte || can_take);
  assign load    = consume && item.last_byte;

  dare_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .last_byte (last_byte),
    .take      (consume),
    .held      (held),
    .item      (item)
  );

  dare_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (consume),
    .item        (item),
    .expected_id (exp_id),
    .result      (result)
  );

  dare_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .result    (result),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .address   (address)
  );

  `ASSERT_NEXT(a_last_loads, clk, rst, load, out_valid, "result not offered")
  `ASSERT_IMPLY(a_addr_zero, clk, rst, out_valid && (status != ST_OK), address == 32'd0, "bad address")
  `ASSERT_IMPLY(a_stall_held, clk, rst, in_stall, held, "stall with empty input register")
  `ASSERT_IMPLY(a_status_range, clk, rst, out_valid, status <= ST_NOA, "status out of range")
  `ASSERT_IMPLY(a_no_overwrite, clk, rst, out_valid && out_stall, !load, "result overwritten")

endmodule

// ===== tb/dns_a_record_extractor_core_tb.sv =====
module dns_a_record_extractor_core_tb;
  import dare_pkg::*;

  typedef enum logic [3:0] {
    WALK_HEADER,
    WALK_LEN,
    WALK_LABEL,
    WALK_PTR,
    WALK_QTAIL,
    WALK_ATAIL,
    WALK_RDATA,
    WALK_DONE
  } walk_phase_t;

  class verdict_board;
    dare_result_t verdicts_due[$];
    int mismatches;
    logic [15:0] want_id;
    walk_phase_t phase;
    logic [3:0] offset;
    logic [15:0] hdr_id, hdr_flags, q_left, a_left, skip_left;
    logic [15:0] rr_type, rr_class, rr_len;
    logic [31:0] addr_acc;
    logic [2:0] verdict;

    function new();
      mismatches = 0;
      want_id = 16'h0000;
      clear_walk();
    endfunction

    function void clear_walk();
      phase = WALK_HEADER;
      offset = 4'd0;
      hdr_id = 16'h0000;
      hdr_flags = 16'h0000;
      q_left = 16'h0000;
      a_left = 16'h0000;
      skip_left = 16'h0000;
      rr_type = 16'h0000;
      rr_class = 16'h0000;
      rr_len = 16'h0000;
      addr_acc = 32'h0;
      verdict = ST_NOA;
    endfunction

    function void set_want_id(logic [15:0] v);
      want_id = v;
    endfunction

    function int open_count();
      return verdicts_due.size();
    endfunction

    function void next_answer();
      if (a_left != 16'h0000) begin
        phase = WALK_LEN;
      end else begin
        phase = WALK_DONE;
        verdict = ST_NOA;
      end
    endfunction

    function void name_done();
      offset = 4'd0;
      phase = (q_left != 16'h0000) ? WALK_QTAIL : WALK_ATAIL;
    endfunction

    function bit is_a_record();
      return rr_type == RR_TYPE_A && rr_class == RR_CLASS_IN && rr_len == A_LEN;
    endfunction

    function void answer_done();
      a_left = a_left - 16'd1;
      next_answer();
    endfunction

    function void walk_reply_byte(logic [7:0] b);
      case (phase)
        WALK_HEADER: begin
          case (offset)
            4'd0: hdr_id = {b, 8'h00};
            4'd1: hdr_id = hdr_id | {8'h00, b};
            4'd2: hdr_flags = {b, 8'h00};
            4'd3: hdr_flags = hdr_flags | {8'h00, b};
            4'd4: q_left = {b, 8'h00};
            4'd5: q_left = q_left | {8'h00, b};
            4'd6: a_left = {b, 8'h00};
            4'd7: a_left = a_left | {8'h00, b};
            default: ;
          endcase
          if (offset < HDR_LAST) begin
            offset = offset + 4'd1;
            verdict = ST_SHORT;
          end else begin
            offset = 4'd0;
            if (hdr_id != want_id) begin
              verdict = ST_IDBAD;
              phase = WALK_DONE;
            end else if (!hdr_flags[15] || hdr_flags[3:0] != 4'h0) begin
              verdict = ST_FLAGBAD;
              phase = WALK_DONE;
            end else begin
              verdict = ST_NOA;
              if (q_left != 16'h0000) phase = WALK_LEN;
              else next_answer();
            end
          end
        end
        WALK_LEN: begin
          if (b == 8'h00) begin
            name_done();
          end else if (b >= PTR_MARK) begin
            phase = WALK_PTR;
          end else begin
            skip_left = {8'h00, b};
            phase = WALK_LABEL;
          end
        end
        WALK_LABEL: begin
          skip_left = skip_left - 16'd1;
          if (skip_left == 16'h0000) phase = WALK_LEN;
        end
        WALK_PTR: name_done();
        WALK_QTAIL: begin
          if (offset < QFIX_LAST) begin
            offset = offset + 4'd1;
          end else begin
            offset = 4'd0;
            q_left = q_left - 16'd1;
            if (q_left != 16'h0000) phase = WALK_LEN;
            else next_answer();
          end
        end
        WALK_ATAIL: begin
          case (offset)
            4'd0: rr_type = {b, 8'h00};
            4'd1: rr_type = rr_type | {8'h00, b};
            4'd2: rr_class = {b, 8'h00};
            4'd3: rr_class = rr_class | {8'h00, b};
            4'd8: rr_len = {b, 8'h00};
            4'd9: rr_len = rr_len | {8'h00, b};
            default: ;
          endcase
          if (offset < AFIX_LAST) begin
            offset = offset + 4'd1;
          end else begin
            offset = 4'd0;
            addr_acc = 32'h0;
            if (rr_len == 16'h0000) begin
              answer_done();
            end else begin
              skip_left = rr_len;
              phase = WALK_RDATA;
            end
          end
        end
        WALK_RDATA: begin
          if (is_a_record()) addr_acc = {addr_acc[23:0], b};
          skip_left = skip_left - 16'd1;
          if (skip_left == 16'h0000) begin
            if (is_a_record()) begin
              verdict = ST_OK;
              phase = WALK_DONE;
            end else begin
              answer_done();
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void note_request(logic [7:0] b, logic last);
      dare_result_t r;
      walk_reply_byte(b);
      if (last) begin
        if (phase == WALK_HEADER) verdict = ST_SHORT;
        r.status = verdict;
        r.address = (verdict == ST_OK) ? addr_acc : 32'h0;
        verdicts_due.push_back(r);
        clear_walk();
      end
    endfunction

    function void check_result(logic [2:0] st, logic [31:0] addr);
      dare_result_t r;
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected result status %0d address %h", $time, st, addr);
        mismatches++;
      end else begin
        r = verdicts_due.pop_front();
        if (st !== r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, r.status, st);
          mismatches++;
        end
        if (addr !== r.address) begin
          $display("%0t: address expected %h actual %h", $time, r.address, addr);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [31:0] address;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] expected_id = 16'h0000;

  verdict_board board;
  logic [7:0] pkt[$];
  logic [15:0] cur_id = 16'h0000;
  int burst_left = 0;
  int stall_span = 0;
  logic [1:0] stall_mode = 2'd0;

  dns_a_record_extractor_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .address    (address),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .expected_id(expected_id)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_span <= 0;
    end else if (stall_span == 0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      stall_span <= $urandom_range(8, 150);
      out_stall <= 1'b0;
    end else begin
      stall_span <= stall_span - 1;
      case (stall_mode)
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= 1'($urandom);
        2'd2: out_stall <= ($urandom_range(0, 7) == 0);
        default: out_stall <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(status, address);
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(b, last);
    burst_left--;
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // hold until every verdict is back and the pipeline is empty
  task automatic drain();
    in_valid <= 1'b0;
    while (board.open_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_id(input logic [15:0] v);
    drain();
    expected_id <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_want_id(v);
    cur_id = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic put16(input logic [15:0] v);
    pkt.push_back(v[15:8]);
    pkt.push_back(v[7:0]);
  endtask

  task automatic put_name();
    int labels;
    int len;
    labels = $urandom_range(0, 3);
    for (int i = 0; i < labels; i++) begin
      if ($urandom_range(0, 39) == 0) len = $urandom_range(64, 191);
      else len = $urandom_range(1, 8);
      pkt.push_back(8'(len));
      repeat (len) pkt.push_back(8'($urandom));
    end
    if ($urandom_range(0, 2) == 0) begin
      pkt.push_back(8'($urandom_range(192, 255)));
      pkt.push_back(8'($urandom));
    end else begin
      pkt.push_back(8'h00);
    end
  endtask

  task automatic put_answer();
    logic [15:0] rtype;
    logic [15:0] rclass;
    logic [15:0] rlen;
    int pick;
    put_name();
    pick = $urandom_range(0, 9);
    if (pick < 6) rtype = RR_TYPE_A;
    else if (pick == 6) rtype = 16'd5;
    else if (pick == 7) rtype = 16'd28;
    else rtype = 16'($urandom);
    rclass = ($urandom_range(0, 5) == 0) ? 16'($urandom) : RR_CLASS_IN;
    if (rtype == RR_TYPE_A && $urandom_range(0, 4) != 0) rlen = A_LEN;
    else rlen = 16'($urandom_range(0, 7));
    put16(rtype);
    put16(rclass);
    repeat (4) pkt.push_back(8'($urandom));
    put16(rlen);
    repeat (rlen) pkt.push_back(8'($urandom));
  endtask

  task automatic build_packet();
    int pick;
    int qd;
    int an;
    int cut;
    pkt.delete();
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 30)) pkt.push_back(8'($urandom));
    end else if (pick < 14) begin
      repeat ($urandom_range(1, 11)) pkt.push_back(8'($urandom));
    end else begin
      put16(($urandom_range(0, 9) == 0) ? 16'($urandom) : cur_id);
      put16(($urandom_range(0, 4) == 0) ? 16'($urandom) : {1'b1, 11'($urandom), 4'h0});
      if (pick < 18) begin
        qd = $urandom_range(0, 65535);
        an = $urandom_range(0, 65535);
      end else begin
        qd = $urandom_range(0, 2);
        an = $urandom_range(0, 3);
      end
      put16(16'(qd));
      put16(16'(an));
      put16(16'($urandom));
      put16(16'($urandom));
      for (int i = 0; i < qd && i < 3; i++) begin
        put_name();
        repeat (4) pkt.push_back(8'($urandom));
      end
      for (int i = 0; i < an && i < 4; i++) put_answer();
      if (pick < 18 || $urandom_range(0, 6) == 0) begin
        cut = $urandom_range(1, pkt.size());
        while (pkt.size() > cut) void'(pkt.pop_back());
      end else if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 5)) pkt.push_back(8'($urandom));
      end
    end
  endtask

  initial begin
    logic [15:0] phase_ids[4];
    int sent;
    int pkts;
    board = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_id(16'h1234);
    send_byte(8'hFF, 1'b1);
    pkt.delete();
    put16(cur_id);
    put16(16'h8000);
    repeat (4) put16(16'h0000);
    send_packet();
    pkt.delete();
    put16(~cur_id);
    put16(16'h0001);
    repeat (4) put16(16'hFFFF);
    send_packet();

    phase_ids = '{16'h0000, 16'hFFFF, 16'($urandom), 16'($urandom)};
    foreach (phase_ids[p]) begin
      write_id(phase_ids[p]);
      sent = 0;
      pkts = 0;
      while (sent < 263 || pkts < 12) begin
        build_packet();
        sent += pkt.size();
        pkts++;
        send_packet();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("dns_a_record_extractor_core: match");
    end else begin
      $display("dns_a_record_extractor_core: mismatch");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("dns_a_record_extractor_core: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/dare_pkg.sv
design/dare_in_reg.sv
design/dare_parser.sv
design/dare_out_reg.sv
design/dns_a_record_extractor_core.sv
tb/dns_a_record_extractor_core_tb.sv
